@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file rsls_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define RSLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk and idle during reset.
`define RSLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/rsls_pkg.sv @@
`default_nettype none
package rsls_pkg;

  localparam int CHANNELS   = 4;
  localparam int OUT_FIELDS = 4;
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int CNT_W      = $clog2(CHANNELS + 1);

  localparam logic [31:0] RNG_RESET   = 32'd341259264;
  localparam logic [11:0] DELAY_RESET = 12'd800;
  localparam logic [11:0] DELAY_MAX   = 12'd4095;
  localparam logic [10:0] DMIN_RESET  = 11'd1050;
  localparam logic [11:0] DSPAN_RESET = 12'd1800;
  localparam logic [5:0]  STEPS_FULL  = 6'd32;

  // ceil(2^40 / 65025). For any cube up to 255^3, bits 47:40 of the cube times
  // this constant equal the cube divided by 65025, rounded down.
  localparam logic [24:0] CUBE_RECIP  = 25'd16909061;

  // Configuration register indexes.
  localparam logic [7:0] REG_MIN_LEVEL   = 8'd0;
  localparam logic [7:0] REG_RAND_OFFSET = 8'd1;
  localparam logic [7:0] REG_DELAY_MIN   = 8'd2;
  localparam logic [7:0] REG_DELAY_SPAN  = 8'd3;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] rem;
  } div_rsp_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] w);
    logic [31:0] a;
    logic [31:0] b;
    a = w ^ (w << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage
`default_nettype wire

@@ hdl/rsls_in_if.sv @@
`default_nettype none
interface rsls_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  modport source (output valid, output now_ms, input ready);
  modport sink (input valid, input now_ms, output ready);
endinterface
`default_nettype wire

@@ hdl/rsls_out_if.sv @@
`default_nettype none
interface rsls_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] level_0;
  logic [7:0] level_1;
  logic [7:0] level_2;
  logic [7:0] level_3;
  modport source (output valid, output level_0, output level_1, output level_2,
                  output level_3, input ready);
  modport sink (input valid, input level_0, input level_1, input level_2,
                input level_3, output ready);
endinterface
`default_nettype wire

@@ hdl/rsls_cfg_if.sv @@
`default_nettype none
interface rsls_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  idx;
  logic [31:0] data;
  modport source (output valid, output idx, output data, input ready);
  modport sink (input valid, input idx, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/rsls_div.sv @@
`default_nettype none
// Restoring divider, one numerator bit per cycle; only the remainder is kept.
module rsls_div import rsls_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [15:0] rem_r;
  logic [31:0] num_r;
  logic [15:0] div_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem_r, num_r[31]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        rem_r  <= '0;
        num_r  <= req.num;
        div_r  <= req.divisor;
        cnt_r  <= req.steps;
      end else if (cnt_r != '0) begin
        rem_r  <= fits ? 16'(trial - {1'b0, div_r}) : trial[15:0];
        num_r  <= {num_r[30:0], 1'b0};
        cnt_r  <= cnt_r - 6'd1;
        done_r <= (cnt_r == 6'd1);
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule
`default_nettype wire

@@ hdl/random_sparkle_led_sequencer_unit.sv @@
// Random sparkle LED sequencer. Each input beat is one update tick carrying the
// current time in ms; each tick returns exactly one output beat with the
// brightness of the four channels. The armed channel is lit once more than its
// start delay has passed since the last start; a xorshift32 generator then arms
// a random dark channel with a delay of delay_min + rand mod delay_span. Every
// lit channel shows phase^3/65025 and sweeps its phase up to 255 and back down
// to min_level. The two random remainders run through one shared restoring
// divider; the cube comes from a small 16x8 multiplier used twice, and the
// divide by 65025 is a multiply by its reciprocal. One tick is handled at a
// time. A start that leaves a channel dark adds one generator step and two
// 32-step divisions at one numerator bit per cycle, the second skipped when
// delay_span is 0. Each lit channel then passes through two multiply steps and
// a scale step. The result is loaded once the previous one has left the output
// register; the sequencer then returns to idle, where a pending configuration
// write goes before the next tick. Writing min_level also sets every phase to
// the new level and keeps the block busy while it recomputes every brightness.
`default_nettype none
module random_sparkle_led_sequencer_unit import rsls_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  rsls_in_if.sink    in_ch,
  rsls_out_if.source out_ch,
  rsls_cfg_if.sink   cfg_ch
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_RNG1   = 4'd2;
  localparam logic [3:0] S_PICK   = 4'd3;
  localparam logic [3:0] S_SPAN   = 4'd4;
  localparam logic [3:0] S_CH     = 4'd5;
  localparam logic [3:0] S_MUL1   = 4'd6;
  localparam logic [3:0] S_MUL2   = 4'd7;
  localparam logic [3:0] S_SCALE  = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  // Configuration.
  logic [7:0]  min_r;
  logic [31:0] offset_r;
  logic [10:0] dmin_r;
  logic [11:0] dspan_r;

  // Channel and sequencing state.
  logic [3:0]      state_r;
  logic [31:0]     now_r;
  logic [31:0]     rng_r;
  logic [7:0]      phase_r [CHANNELS];
  logic [CHANNELS-1:0] rising_r;
  logic [CHANNELS-1:0] lit_r;
  logic [11:0]     delay_r [CHANNELS];
  logic [7:0]      bright_r [CHANNELS];
  logic [CH_W-1:0] armed_r;
  logic            lock_r;
  logic [31:0]     last_r;
  logic [CNT_W-1:0] count_r;
  logic [CH_W-1:0] ch_r;
  logic [7:0]      x_r;
  logic [23:0]     prod_r;
  logic            cfg_mode_r;
  logic [7:0]      lvl_r [OUT_FIELDS];
  logic            out_valid_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rsls_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // The generator word after one and after two steps is taken from rng_r;
  // S_PICK takes the second once rng_r holds the first, so one function suffices.
  logic [31:0] rng_next;
  assign rng_next = xorshift32(rng_r);

  // Start test on the armed channel; the elapsed time wraps modulo 2^32.
  logic [31:0] elapsed;
  logic        start_now;
  logic [CHANNELS-1:0] lit_start;
  logic [CNT_W-1:0]    dark_cnt;
  assign elapsed   = now_r - last_r;
  assign start_now = !lit_r[armed_r] && (elapsed > {20'd0, delay_r[armed_r]});

  always_comb begin
    lit_start = lit_r;
    lit_start[armed_r] = 1'b1;
    dark_cnt = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (!lit_start[k]) dark_cnt = dark_cnt + CNT_W'(1);
    end
  end

  // Pick the n-th dark channel, n being the remainder of the first division.
  logic [CH_W-1:0]  pick_ch;
  logic [CNT_W-1:0] seen;
  always_comb begin
    pick_ch = '0;
    seen    = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (!lit_r[k]) begin
        if (seen == div_rsp.rem[CNT_W-1:0]) pick_ch = CH_W'(k);
        seen = seen + CNT_W'(1);
      end
    end
  end

  // Phase step of the channel under the sequencer. The top check comes first,
  // so with min_level at 255 the bottom check wins and the phase wraps up.
  logic [7:0] cur_phase;
  logic       dir;
  logic [7:0] new_phase;
  assign cur_phase = phase_r[ch_r];
  always_comb begin
    dir = rising_r[ch_r];
    if (cur_phase == 8'd255) dir = 1'b0;
    if (cur_phase == min_r) dir = 1'b1;
    new_phase = dir ? cur_phase + 8'd1 : cur_phase - 8'd1;
  end

  // Start delay from the second division, saturated to twelve bits.
  logic [12:0] dsum;
  logic [11:0] dsat;
  assign dsum = {2'b00, dmin_r} + {1'b0, div_rsp.rem[11:0]};
  assign dsat = dsum[12] ? DELAY_MAX : dsum[11:0];

  // The small multiplier serves both cubing steps.
  logic [15:0] mul_a;
  logic [23:0] mul_p;
  assign mul_a = (state_r == S_MUL1) ? {8'd0, x_r} : prod_r[15:0];
  assign mul_p = mul_a * x_r;

  // The cube is at most 255^3, so the scaled value's bits 47:40 hold the
  // quotient by 65025 and it never exceeds 255.
  logic [48:0] scaled;
  logic [7:0]  cube_q;
  assign scaled = prod_r * CUBE_RECIP;
  assign cube_q = scaled[47:40];

  logic last_ch;
  assign last_ch = (ch_r == CH_W'(CHANNELS - 1));

  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_RNG1: begin
        div_req.start   = 1'b1;
        div_req.num     = rng_next + offset_r;
        div_req.divisor = 16'(count_r);
        div_req.steps   = STEPS_FULL;
      end
      S_PICK: begin
        div_req.start   = div_rsp.done && (dspan_r != '0);
        div_req.num     = rng_next + offset_r;
        div_req.divisor = {4'd0, dspan_r};
        div_req.steps   = STEPS_FULL;
      end
      default: div_req = '0;
    endcase
  end

  logic in_acc;
  logic cfg_acc;
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_r       <= '0;
      offset_r    <= '0;
      dmin_r      <= DMIN_RESET;
      dspan_r     <= DSPAN_RESET;
      rng_r       <= RNG_RESET;
      rising_r    <= '1;
      lit_r       <= '0;
      armed_r     <= '0;
      lock_r      <= 1'b0;
      last_r      <= '0;
      ch_r        <= '0;
      cfg_mode_r  <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        phase_r[k]  <= '0;
        delay_r[k]  <= DELAY_RESET;
        bright_r[k] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cfg_acc) begin
            unique case (cfg_ch.idx)
              REG_MIN_LEVEL: begin
                // Every phase takes the new level and every brightness its cubic.
                min_r <= cfg_ch.data[7:0];
                x_r   <= cfg_ch.data[7:0];
                for (int k = 0; k < CHANNELS; k++) phase_r[k] <= cfg_ch.data[7:0];
                cfg_mode_r <= 1'b1;
                state_r    <= S_MUL1;
              end
              REG_RAND_OFFSET: offset_r <= cfg_ch.data;
              REG_DELAY_MIN:   dmin_r   <= cfg_ch.data[10:0];
              REG_DELAY_SPAN:  dspan_r  <= cfg_ch.data[11:0];
              default: ;
            endcase
          end else if (in_acc) begin
            now_r   <= in_ch.now_ms;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          ch_r <= '0;
          if (start_now) begin
            lit_r   <= lit_start;
            last_r  <= now_r;
            count_r <= dark_cnt;
            if (dark_cnt != '0) begin
              state_r <= S_RNG1;
            end else begin
              lock_r  <= 1'b1;
              state_r <= S_CH;
            end
          end else begin
            state_r <= S_CH;
          end
        end
        S_RNG1: begin
          rng_r   <= rng_next;
          state_r <= S_PICK;
        end
        S_PICK: begin
          if (div_rsp.done) begin
            armed_r <= pick_ch;
            rng_r   <= rng_next;
            if (dspan_r != '0) begin
              state_r <= S_SPAN;
            end else begin
              delay_r[pick_ch] <= {1'b0, dmin_r};
              state_r <= S_CH;
            end
          end
        end
        S_SPAN: begin
          if (div_rsp.done) begin
            delay_r[armed_r] <= dsat;
            state_r <= S_CH;
          end
        end
        S_CH: begin
          if (lit_r[ch_r]) begin
            x_r            <= cur_phase;
            rising_r[ch_r] <= dir;
            phase_r[ch_r]  <= new_phase;
            if (new_phase == min_r) begin
              lit_r[ch_r] <= 1'b0;
              if (lock_r) begin
                armed_r <= ch_r;
                lock_r  <= 1'b0;
              end
            end
            state_r <= S_MUL1;
          end else if (last_ch) begin
            state_r <= S_OUT;
          end else begin
            ch_r <= ch_r + CH_W'(1);
          end
        end
        S_MUL1: begin
          prod_r  <= mul_p;
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          prod_r  <= mul_p;
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          if (cfg_mode_r) begin
            for (int k = 0; k < CHANNELS; k++) bright_r[k] <= cube_q;
            cfg_mode_r <= 1'b0;
            state_r    <= S_IDLE;
          end else begin
            bright_r[ch_r] <= cube_q;
            if (last_ch) begin
              state_r <= S_OUT;
            end else begin
              ch_r    <= ch_r + CH_W'(1);
              state_r <= S_CH;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            for (int k = 0; k < OUT_FIELDS; k++) begin
              lvl_r[k] <= (k < CHANNELS) ? bright_r[k] : 8'd0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The output register fills when the sequencer hands over a result and
  // empties when the receiver takes the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.level_0 = lvl_r[0];
  assign out_ch.level_1 = lvl_r[1];
  assign out_ch.level_2 = lvl_r[2];
  assign out_ch.level_3 = lvl_r[3];

endmodule
`default_nettype wire

@@ hdl/rsls_chk.sv @@
`default_nettype none
`include "assert_macros.svh"
module rsls_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] level_0,
  input wire logic [7:0] level_1,
  input wire logic [7:0] level_2,
  input wire logic [7:0] level_3
);

  logic in_acc;
  logic cfg_acc;
  logic out_stall;
  logic [31:0] levels;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_stall = out_valid && !out_ready;
  assign levels    = {level_0, level_1, level_2, level_3};

  `RSLS_ASSERT_NEXT(a_out_hold, out_stall, out_valid)
  `RSLS_ASSERT_NEXT(a_out_stable, out_stall, $stable(levels))
  `RSLS_ASSERT_IMP(a_no_dual_accept, in_acc, !cfg_acc)
  `RSLS_ASSERT_NEXT(a_busy_after_tick, in_acc, !in_ready)
  `RSLS_ASSERT_IMP(a_result_from_work, $rose(out_valid), !$past(in_ready))

endmodule

bind random_sparkle_led_sequencer_unit rsls_chk u_rsls_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .level_0   (out_ch.level_0),
  .level_1   (out_ch.level_1),
  .level_2   (out_ch.level_2),
  .level_3   (out_ch.level_3)
);
`default_nettype wire
